// ===== sv/itar_pkg.sv =====
// Package for the integer to ASCII converter: widths, command and radix
// codes, controller states, character constants and the digit encoder.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps

package itar_pkg;

  // Width of the converted integer.
  localparam int ValueWidth = 16;

  // The longest text is the octal one: one digit per three bits.
  localparam int StackDepth = (ValueWidth + 2) / 3;
  localparam int CountWidth = $clog2(StackDepth + 1);
  localparam int IndexWidth = $clog2(StackDepth);

  // Reciprocal of ten, scaled by 2**35; exact for every 32-bit dividend.
  localparam logic [31:0] RecipTen   = 32'hCCCC_CCCD;
  localparam int          RecipShift = 35;

  // ASCII codes.
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharLowA  = 7'h61;
  localparam logic [6:0] CharUpA   = 7'h41;
  localparam logic [6:0] CharMinus = 7'h2D;
  localparam logic [3:0] DigitTen  = 4'd10;

  typedef enum logic [2:0] {
    CMD_SDEC = 3'd0,
    CMD_UDEC = 3'd1,
    CMD_OCT  = 3'd2,
    CMD_LHEX = 3'd3,
    CMD_UHEX = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  // Control from the sequencer to the digit stack.
  typedef struct packed {
    logic push;
    logic pop;
  } stack_ctrl_t;

  // Maps one digit value to its ASCII character.
  function automatic logic [6:0] digit_char(input logic [3:0] digit, input logic upper);
    logic [6:0] base;
    begin
      if (digit < DigitTen) begin
        digit_char = CharZero + {3'b000, digit};
      end else begin
        base = upper ? CharUpA : CharLowA;
        digit_char = base + {3'b000, digit - DigitTen};
      end
    end
  endfunction

endpackage

// ===== sv/itar_div.sv =====
// Shared divide-by-radix unit: one quotient per cycle, plus the digit that
// the previous step left. Depends on itar_pkg.
`timescale 1ns / 1ps

module itar_div (
  input  logic [itar_pkg::ValueWidth-1:0] work_i,
  input  logic [3:0]                      prev_i,
  input  itar_pkg::radix_e                radix_i,
  output logic [itar_pkg::ValueWidth-1:0] quot_o,
  output logic [3:0]                      digit_o
);

  localparam int ProdWidth = itar_pkg::ValueWidth + 32;

  logic [ProdWidth-1:0] prod;
  logic [3:0]           wlo;
  logic [3:0]           sub;

  // Decimal uses the scaled reciprocal; octal and hex are plain shifts.
  assign prod = ProdWidth'(work_i) * ProdWidth'(itar_pkg::RecipTen);

  always_comb begin
    case (radix_i)
      itar_pkg::RADIX_DEC: quot_o = itar_pkg::ValueWidth'(prod >> itar_pkg::RecipShift);
      itar_pkg::RADIX_OCT: quot_o = work_i >> 3;
      itar_pkg::RADIX_HEX: quot_o = work_i >> 4;
      default:             quot_o = work_i >> 4;
    endcase
  end

  // The remainder is prev - radix * quotient; modulo 16 only the low
  // nibbles of both take part.
  assign wlo = work_i[3:0];

  always_comb begin
    case (radix_i)
      itar_pkg::RADIX_DEC: sub = 4'({wlo, 3'b000} + {3'b000, wlo, 1'b0});
      itar_pkg::RADIX_OCT: sub = {wlo[0], 3'b000};
      itar_pkg::RADIX_HEX: sub = 4'd0;
      default:             sub = 4'd0;
    endcase
  end

  assign digit_o = prev_i - sub;

endmodule

// ===== sv/itar_stack.sv =====
// Digit stack: digits arrive least significant first and leave most
// significant first. Depends on itar_pkg.
`timescale 1ns / 1ps

module itar_stack (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  itar_pkg::stack_ctrl_t           ctrl_i,
  input  logic [3:0]                      digit_i,
  output logic [3:0]                      top_o,
  output logic [itar_pkg::CountWidth-1:0] count_o
);

  logic [3:0]                      entries_q [itar_pkg::StackDepth];
  logic [itar_pkg::CountWidth-1:0] count_q, count_d;
  logic [itar_pkg::CountWidth-1:0] top_cnt;

  assign top_cnt = count_q - itar_pkg::CountWidth'(1);
  assign top_o   = entries_q[top_cnt[itar_pkg::IndexWidth-1:0]];
  assign count_o = count_q;

  // Fill count tracks the number of stored digits.
  always_comb begin
    count_d = count_q;
    if (ctrl_i.push) begin
      count_d = count_q + itar_pkg::CountWidth'(1);
    end else if (ctrl_i.pop) begin
      count_d = top_cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Digit storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      entries_q[count_q[itar_pkg::IndexWidth-1:0]] <= digit_i;
    end
  end

endmodule

// ===== sv/integer_to_ascii_radix.sv =====
// Top level of the integer to ASCII converter: sequencer and output stage.
// Depends on itar_pkg, itar_div and itar_stack.
`timescale 1ns / 1ps

// Usage
// A transaction is accepted at a rising edge with start high and busy low;
// command_i selects signed decimal, unsigned decimal, octal, lowercase hex
// or uppercase hex, and value_i carries the integer bits. Command codes
// above uppercase hex are dropped: busy stays low and nothing is emitted.
// The block answers with one ASCII character per cycle on character_o,
// marked by result_valid_o, most significant digit first; last_o flags the
// final character. A negative signed decimal value starts with '-'.
// Timing: busy rises the cycle after acceptance. The shared divider
// produces one digit per cycle (a zero value counts as one digit), then
// the digit stack empties one character per cycle, after a minus sign if
// there is one. The next transaction can be accepted in the cycle the
// last character is on the ports.
// Reset clears the sequencer, the digit stack and the result strobe. The
// receiver cannot stall; each character is shown for exactly one cycle.

module integer_to_ascii_radix (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [2:0]                      command_i,
  input  logic [itar_pkg::ValueWidth-1:0] value_i,
  output logic                            result_valid_o,
  output logic [6:0]                      character_o,
  output logic                            last_o
);

  localparam int W = itar_pkg::ValueWidth;

  itar_pkg::state_e state_q, state_d;
  itar_pkg::radix_e radix_q, radix_d;
  logic [W-1:0]     work_q, work_d;
  logic [3:0]       prev_q, prev_d;
  logic             pend_q, pend_d;
  logic             first_q, first_d;
  logic             neg_q, neg_d;
  logic             upper_q, upper_d;
  logic             valid_q, valid_d;
  logic [6:0]       char_q, char_d;
  logic             last_q, last_d;

  itar_pkg::stack_ctrl_t           stack_ctrl;
  logic [W-1:0]                    quot;
  logic [3:0]                      digit;
  logic [3:0]                      top_digit;
  logic [itar_pkg::CountWidth-1:0] count;
  logic [W-1:0]                    mag;
  logic                            sign_neg;

  // Shared arithmetic unit.
  itar_div u_div (
    .work_i  (work_q),
    .prev_i  (prev_q),
    .radix_i (radix_q),
    .quot_o  (quot),
    .digit_o (digit)
  );

  // Digit reversal.
  itar_stack u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stack_ctrl),
    .digit_i (digit),
    .top_o   (top_digit),
    .count_o (count)
  );

  // Magnitude of a negative signed decimal value.
  assign sign_neg = value_i[W-1];
  assign mag      = (itar_pkg::cmd_e'(command_i) == itar_pkg::CMD_SDEC && sign_neg)
                    ? W'(~value_i + W'(1)) : value_i;

  // Sequencer: next state and control.
  always_comb begin
    state_d         = state_q;
    radix_d         = radix_q;
    work_d          = work_q;
    prev_d          = prev_q;
    pend_d          = pend_q;
    first_d         = first_q;
    neg_d           = neg_q;
    upper_d         = upper_q;
    valid_d         = 1'b0;
    char_d          = char_q;
    last_d          = last_q;
    stack_ctrl.push = 1'b0;
    stack_ctrl.pop  = 1'b0;

    case (state_q)
      itar_pkg::ST_IDLE: begin
        if (start) begin
          work_d  = mag;
          first_d = 1'b1;
          pend_d  = 1'b0;
          neg_d   = 1'b0;
          upper_d = 1'b0;
          state_d = itar_pkg::ST_DIV;
          case (itar_pkg::cmd_e'(command_i))
            itar_pkg::CMD_SDEC: begin
              radix_d = itar_pkg::RADIX_DEC;
              neg_d   = sign_neg;
            end
            itar_pkg::CMD_UDEC: radix_d = itar_pkg::RADIX_DEC;
            itar_pkg::CMD_OCT:  radix_d = itar_pkg::RADIX_OCT;
            itar_pkg::CMD_LHEX: radix_d = itar_pkg::RADIX_HEX;
            itar_pkg::CMD_UHEX: begin
              radix_d = itar_pkg::RADIX_HEX;
              upper_d = 1'b1;
            end
            default: state_d = itar_pkg::ST_IDLE;
          endcase
        end
      end

      itar_pkg::ST_DIV: begin
        // The digit of the previous step is stored here, in the cycle after that step.
        stack_ctrl.push = pend_q;
        if (work_q != '0 || first_q) begin
          work_d  = quot;
          prev_d  = work_q[3:0];
          pend_d  = 1'b1;
          first_d = 1'b0;
        end else begin
          pend_d  = 1'b0;
          state_d = itar_pkg::ST_EMIT;
        end
      end

      itar_pkg::ST_EMIT: begin
        valid_d = 1'b1;
        if (neg_q) begin
          char_d = itar_pkg::CharMinus;
          last_d = 1'b0;
          neg_d  = 1'b0;
        end else begin
          stack_ctrl.pop = 1'b1;
          char_d = itar_pkg::digit_char(top_digit, upper_q);
          last_d = (count == itar_pkg::CountWidth'(1));
          if (count == itar_pkg::CountWidth'(1)) begin
            state_d = itar_pkg::ST_IDLE;
          end
        end
      end

      default: state_d = itar_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itar_pkg::ST_IDLE;
      pend_q  <= 1'b0;
      first_q <= 1'b0;
      neg_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      first_q <= first_d;
      neg_q   <= neg_d;
      valid_q <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    radix_q <= radix_d;
    work_q  <= work_d;
    prev_q  <= prev_d;
    upper_q <= upper_d;
    char_q  <= char_d;
    last_q  <= last_d;
  end

  assign busy           = (state_q != itar_pkg::ST_IDLE);
  assign result_valid_o = valid_q;
  assign character_o    = char_q;
  assign last_o         = valid_q & last_q;

endmodule

// ===== sv/itar_checker.sv =====
// Port-level checks for the integer to ASCII converter, bound to the top
// level. Depends on itar_pkg and integer_to_ascii_radix.
`timescale 1ns / 1ps

module itar_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start,
  input logic       busy,
  input logic [2:0] command_i,
  input logic       result_valid_o,
  input logic       last_o
);

  // A character only follows a cycle in which the block was busy.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a busy cycle before it");

  // A supported command starts a conversion.
  a_valid_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i <= 3'(itar_pkg::CMD_UHEX)) |=> busy)
    else $error("accepted command did not start a conversion");

  // An unsupported command is dropped at once.
  a_bad_cmd_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && command_i > 3'(itar_pkg::CMD_UHEX)) |=> !busy)
    else $error("unsupported command left the block busy");

  // The last flag only rides on a character.
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> result_valid_o)
    else $error("last flag without a result strobe");

  // The final character is not followed by a character in the next cycle.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_o) |=> !result_valid_o)
    else $error("character right after the final character");

endmodule

bind integer_to_ascii_radix itar_checker u_itar_checker (.*);
